### hw/rtl/enms_pkg.sv
// Package for the edge non-maximum suppression block.
// Holds the edge class codes and the side-term bundle used by the pipeline.
// Depends on nothing.
package enms_pkg;

    localparam int MagW  = 15;
    localparam int GradW = 16;
    localparam int DiffW = MagW + 1;
    localparam int ProdW = DiffW + GradW + 1;

    typedef logic [1:0] t_edge_class;

    localparam t_edge_class ClassBorder   = 2'd0;
    localparam t_edge_class ClassNoEdge   = 2'd1;
    localparam t_edge_class ClassPossible = 2'd2;

    typedef logic [MagW-1:0] t_mag;

    typedef struct packed {
        logic signed [DiffW-1:0] a1;
        logic signed [DiffW-1:0] b1;
        logic signed [DiffW-1:0] a2;
        logic signed [DiffW-1:0] b2;
    } t_side_terms;

endpackage

### hw/rtl/enms_if.sv
// Handshake interfaces for the pixel word and the class word.
// Depends on enms_pkg.
interface enms_pix_if import enms_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;
    t_mag                    mag_center;
    t_mag                    mag_up;
    t_mag                    mag_down;
    t_mag                    mag_left;
    t_mag                    mag_right;
    t_mag                    mag_up_left;
    t_mag                    mag_up_right;
    t_mag                    mag_down_left;
    t_mag                    mag_down_right;
    logic                    on_border;

    modport source (
        output valid, grad_x, grad_y, mag_center, mag_up, mag_down, mag_left, mag_right,
               mag_up_left, mag_up_right, mag_down_left, mag_down_right, on_border,
        input  ready
    );
    modport sink (
        input  valid, grad_x, grad_y, mag_center, mag_up, mag_down, mag_left, mag_right,
               mag_up_left, mag_up_right, mag_down_left, mag_down_right, on_border,
        output ready
    );
endinterface

interface enms_cls_if import enms_pkg::*; ();
    logic        valid;
    logic        ready;
    t_edge_class edge_class;

    modport source (output valid, edge_class, input ready);
    modport sink (input valid, edge_class, output ready);
endinterface

### hw/rtl/enms_sector_sel.sv
// Gradient sector decode and selection of the interpolation differences.
// Purely combinational; depends on enms_pkg.
module enms_sector_sel import enms_pkg::*; (
    input  logic signed [GradW-1:0] i_grad_x,
    input  logic signed [GradW-1:0] i_grad_y,
    input  t_mag                    i_c,
    input  t_mag                    i_up,
    input  t_mag                    i_dn,
    input  t_mag                    i_lf,
    input  t_mag                    i_rt,
    input  t_mag                    i_ul,
    input  t_mag                    i_ur,
    input  t_mag                    i_dl,
    input  t_mag                    i_dr,
    output t_side_terms             o_terms
);

    function automatic logic signed [DiffW-1:0] diff(input t_mag x, input t_mag y);
        diff = $signed({1'b0, x}) - $signed({1'b0, y});
    endfunction

    logic signed [GradW:0] gx_w;
    logic signed [GradW:0] gy_w;
    logic signed [GradW:0] ngx_w;
    logic signed [GradW:0] ngy_w;

    assign gx_w  = {i_grad_x[GradW-1], i_grad_x};
    assign gy_w  = {i_grad_y[GradW-1], i_grad_y};
    assign ngx_w = -gx_w;
    assign ngy_w = -gy_w;

    always_comb begin
        o_terms = '0;
        if (!i_grad_x[GradW-1]) begin
            if (!i_grad_y[GradW-1]) begin
                if (gx_w >= gy_w) begin
                    o_terms = '{diff(i_c, i_lf), diff(i_ul, i_lf),
                                diff(i_c, i_rt), diff(i_dr, i_rt)};
                end else begin
                    o_terms = '{diff(i_up, i_ul), diff(i_up, i_c),
                                diff(i_dn, i_dr), diff(i_dn, i_c)};
                end
            end else begin
                if (gx_w >= ngy_w) begin
                    o_terms = '{diff(i_c, i_lf), diff(i_lf, i_dl),
                                diff(i_c, i_rt), diff(i_rt, i_ur)};
                end else begin
                    o_terms = '{diff(i_dn, i_dl), diff(i_c, i_dn),
                                diff(i_up, i_ur), diff(i_c, i_up)};
                end
            end
        end else begin
            if (!i_grad_y[GradW-1]) begin
                if (ngx_w >= gy_w) begin
                    o_terms = '{diff(i_rt, i_c), diff(i_ur, i_rt),
                                diff(i_lf, i_c), diff(i_dl, i_lf)};
                end else begin
                    o_terms = '{diff(i_ur, i_up), diff(i_up, i_c),
                                diff(i_dl, i_dn), diff(i_dn, i_c)};
                end
            end else begin
                if (ngx_w > ngy_w) begin
                    o_terms = '{diff(i_rt, i_c), diff(i_rt, i_dr),
                                diff(i_lf, i_c), diff(i_lf, i_ul)};
                end else begin
                    o_terms = '{diff(i_dr, i_dn), diff(i_c, i_dn),
                                diff(i_ul, i_up), diff(i_c, i_up)};
                end
            end
        end
    end

endmodule

### hw/rtl/edge_non_max_suppression.sv
// Edge non-maximum suppression, top level.
// Throughput is one word per cycle; the ready chain stalls only when the output is held.
// Stages: input register, sector selection register, cross product and class register.
// Reset (synchronous, active low) empties all three stages; no state spans pixels.
// Depends on enms_pkg, enms_if and enms_sector_sel.
module edge_non_max_suppression import enms_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    enms_pix_if.sink      i_pix,
    enms_cls_if.source    o_cls
);

    logic en0;
    logic en1;
    logic en2;

    logic                    r0_valid;
    logic signed [GradW-1:0] r0_gx;
    logic signed [GradW-1:0] r0_gy;
    t_mag                    r0_c;
    t_mag                    r0_up;
    t_mag                    r0_dn;
    t_mag                    r0_lf;
    t_mag                    r0_rt;
    t_mag                    r0_ul;
    t_mag                    r0_ur;
    t_mag                    r0_dl;
    t_mag                    r0_dr;
    logic                    r0_border;

    t_side_terms             n1_terms;
    logic                    r1_valid;
    t_side_terms             r1_terms;
    logic signed [GradW:0]   r1_nx;
    logic signed [GradW-1:0] r1_gy;
    logic                    r1_fixed;
    t_edge_class             r1_fixed_cls;

    logic signed [ProdW-1:0] p1a;
    logic signed [ProdW-1:0] p1b;
    logic signed [ProdW-1:0] p2a;
    logic signed [ProdW-1:0] p2b;
    logic signed [ProdW:0]   m1;
    logic signed [ProdW:0]   m2;
    logic                    m1_pos;
    logic                    m2_neg;
    t_edge_class             n2_cls;
    logic                    r2_valid;
    t_edge_class             r2_cls;

    assign en2 = !r2_valid || o_cls.ready;
    assign en1 = !r1_valid || en2;
    assign en0 = !r0_valid || en1;
    assign i_pix.ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (en0) begin
                r0_valid <= i_pix.valid;
            end
            if (en1) begin
                r1_valid <= r0_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_pix.valid) begin
            r0_gx     <= i_pix.grad_x;
            r0_gy     <= i_pix.grad_y;
            r0_c      <= i_pix.mag_center;
            r0_up     <= i_pix.mag_up;
            r0_dn     <= i_pix.mag_down;
            r0_lf     <= i_pix.mag_left;
            r0_rt     <= i_pix.mag_right;
            r0_ul     <= i_pix.mag_up_left;
            r0_ur     <= i_pix.mag_up_right;
            r0_dl     <= i_pix.mag_down_left;
            r0_dr     <= i_pix.mag_down_right;
            r0_border <= i_pix.on_border;
        end
    end

    enms_sector_sel u_sector_sel (
        .i_grad_x (r0_gx),
        .i_grad_y (r0_gy),
        .i_c      (r0_c),
        .i_up     (r0_up),
        .i_dn     (r0_dn),
        .i_lf     (r0_lf),
        .i_rt     (r0_rt),
        .i_ul     (r0_ul),
        .i_ur     (r0_ur),
        .i_dl     (r0_dl),
        .i_dr     (r0_dr),
        .o_terms  (n1_terms)
    );

    always_ff @(posedge i_clk) begin
        if (en1 && r0_valid) begin
            r1_terms     <= n1_terms;
            r1_nx        <= -{r0_gx[GradW-1], r0_gx};
            r1_gy        <= r0_gy;
            r1_fixed     <= r0_border || (r0_c == '0);
            r1_fixed_cls <= r0_border ? ClassBorder : ClassNoEdge;
        end
    end

    // A pixel is kept only when neither side rises above it and the second side falls below.
    assign p1a = r1_terms.a1 * r1_nx;
    assign p1b = r1_terms.b1 * r1_gy;
    assign p2a = r1_terms.a2 * r1_nx;
    assign p2b = r1_terms.b2 * r1_gy;
    assign m1  = {p1a[ProdW-1], p1a} + {p1b[ProdW-1], p1b};
    assign m2  = {p2a[ProdW-1], p2a} + {p2b[ProdW-1], p2b};
    assign m1_pos = !m1[ProdW] && (m1 != '0);
    assign m2_neg = m2[ProdW];

    always_comb begin
        if (r1_fixed) begin
            n2_cls = r1_fixed_cls;
        end else if (!m1_pos && m2_neg) begin
            n2_cls = ClassPossible;
        end else begin
            n2_cls = ClassNoEdge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_cls <= n2_cls;
        end
    end

    assign o_cls.valid      = r2_valid;
    assign o_cls.edge_class = r2_cls;

endmodule

### bench/tb_edge_non_max_suppression.sv
// Self-checking bench for the edge non-maximum suppression block: pixel words go in on
// the pixel channel, class words are compared against an in-bench sector predictor.
// Depends on enms_pkg, enms_if and the edge_non_max_suppression top level.
`timescale 1ns / 100ps

module tb_edge_non_max_suppression;
    import enms_pkg::*;

    localparam int RandomWords = 1900;
    localparam int LongHold    = 300;
    localparam int HoldAtWord  = 600;
    localparam int CycleLimit  = 400000;

    typedef struct {
        logic signed [GradW-1:0] grad_x;
        logic signed [GradW-1:0] grad_y;
        t_mag                    mag_center;
        t_mag                    mag_up;
        t_mag                    mag_down;
        t_mag                    mag_left;
        t_mag                    mag_right;
        t_mag                    mag_up_left;
        t_mag                    mag_up_right;
        t_mag                    mag_down_left;
        t_mag                    mag_down_right;
        logic                    on_border;
    } t_pix_word;

    class edge_class_scoreboard;
        t_edge_class expected_classes[$];
        int unsigned mismatches;

        function longint side_sum(longint a, longint b, longint nx, longint gy);
            return a * nx + b * gy;
        endfunction

        function t_edge_class predict_class(t_pix_word p);
            longint gx, gy, nx, c, up, dn, lf, rt, ul, ur, dl, dr, s1, s2;
            gx = p.grad_x;
            gy = p.grad_y;
            nx = -gx;
            c  = p.mag_center;
            up = p.mag_up;
            dn = p.mag_down;
            lf = p.mag_left;
            rt = p.mag_right;
            ul = p.mag_up_left;
            ur = p.mag_up_right;
            dl = p.mag_down_left;
            dr = p.mag_down_right;
            if (p.on_border) begin
                return ClassBorder;
            end
            if (c == 0) begin
                return ClassNoEdge;
            end
            if (gx >= 0) begin
                if (gy >= 0) begin
                    if (gx >= gy) begin
                        s1 = side_sum(c - lf, ul - lf, nx, gy);
                        s2 = side_sum(c - rt, dr - rt, nx, gy);
                    end else begin
                        s1 = side_sum(up - ul, up - c, nx, gy);
                        s2 = side_sum(dn - dr, dn - c, nx, gy);
                    end
                end else begin
                    if (gx >= -gy) begin
                        s1 = side_sum(c - lf, lf - dl, nx, gy);
                        s2 = side_sum(c - rt, rt - ur, nx, gy);
                    end else begin
                        s1 = side_sum(dn - dl, c - dn, nx, gy);
                        s2 = side_sum(up - ur, c - up, nx, gy);
                    end
                end
            end else begin
                if (gy >= 0) begin
                    if (-gx >= gy) begin
                        s1 = side_sum(rt - c, ur - rt, nx, gy);
                        s2 = side_sum(lf - c, dl - lf, nx, gy);
                    end else begin
                        s1 = side_sum(ur - up, up - c, nx, gy);
                        s2 = side_sum(dl - dn, dn - c, nx, gy);
                    end
                end else begin
                    // Both components negative: a tie falls to the vertical sector here.
                    if (-gx > -gy) begin
                        s1 = side_sum(rt - c, rt - dr, nx, gy);
                        s2 = side_sum(lf - c, lf - ul, nx, gy);
                    end else begin
                        s1 = side_sum(dr - dn, c - dn, nx, gy);
                        s2 = side_sum(ul - up, c - up, nx, gy);
                    end
                end
            end
            if (s1 > 0 || s2 > 0 || s2 == 0) begin
                return ClassNoEdge;
            end
            return ClassPossible;
        endfunction

        function void note_pixel(t_pix_word p);
            expected_classes.push_back(predict_class(p));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 100) begin
                $display("%0t: mismatch: %s", $time, what);
            end
        endtask

        task check_class(t_edge_class got);
            t_edge_class want;
            if (expected_classes.size() == 0) begin
                report_mismatch($sformatf("class word %0d with no pixel word pending", got));
            end else begin
                want = expected_classes.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("edge_class %0d, expected %0d", got, want));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned cycle_count;

    edge_class_scoreboard sb;

    enms_pix_if pix_if ();
    enms_cls_if cls_if ();

    edge_non_max_suppression DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_cls   (cls_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("edge_non_max_suppression verification failed");
            $finish;
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic signed [GradW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic t_pix_word make_pixel(int gx, int gy, int c, int nb, bit border);
        t_pix_word p;
        p.grad_x         = 16'(gx);
        p.grad_y         = 16'(gy);
        p.mag_center     = 15'(c);
        p.mag_up         = 15'(nb);
        p.mag_down       = 15'(nb);
        p.mag_left       = 15'(nb);
        p.mag_right      = 15'(nb);
        p.mag_up_left    = 15'(nb);
        p.mag_up_right   = 15'(nb);
        p.mag_down_left  = 15'(nb);
        p.mag_down_right = 15'(nb);
        p.on_border      = border;
        return p;
    endfunction

    // Entered just after a falling edge; returns just after the falling edge that
    // follows acceptance, with valid left high so a back-to-back word needs no toggle.
    task automatic send_pixel(t_pix_word p, int gap);
        if (gap > 0) begin
            pix_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.grad_x         = p.grad_x;
        pix_if.grad_y         = p.grad_y;
        pix_if.mag_center     = p.mag_center;
        pix_if.mag_up         = p.mag_up;
        pix_if.mag_down       = p.mag_down;
        pix_if.mag_left       = p.mag_left;
        pix_if.mag_right      = p.mag_right;
        pix_if.mag_up_left    = p.mag_up_left;
        pix_if.mag_up_right   = p.mag_up_right;
        pix_if.mag_down_left  = p.mag_down_left;
        pix_if.mag_down_right = p.mag_down_right;
        pix_if.on_border      = p.on_border;
        pix_if.valid          = 1'b1;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.expected_classes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int stall;
        int served;
        bit quiet;
        cls_if.ready = 1'b0;
        served = 0;
        quiet = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (served % 64 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (served == HoldAtWord) begin
                cls_if.ready = 1'b0;
                for (int k = 0; k < LongHold; k++) begin
                    @(negedge i_clk);
                end
            end
            stall = draw_gap(quiet);
            if (stall > 0) begin
                cls_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            cls_if.ready = 1'b1;
            do @(posedge i_clk); while (!cls_if.valid);
            sb.check_class(cls_if.edge_class);
            served++;
            @(negedge i_clk);
        end
    end

    initial begin
        t_pix_word directed_words[$];
        t_pix_word p;
        t_mag      nb[8];
        int        c;
        int        d;
        int        mode;
        bit        tx_quiet;

        sb = new();
        tx_quiet = 1'b0;
        p = make_pixel(0, 0, 0, 0, 1'b0);
        pix_if.valid = 1'b0;
        send_fields_idle: begin
            pix_if.grad_x         = '0;
            pix_if.grad_y         = '0;
            pix_if.mag_center     = '0;
            pix_if.mag_up         = '0;
            pix_if.mag_down       = '0;
            pix_if.mag_left       = '0;
            pix_if.mag_right      = '0;
            pix_if.mag_up_left    = '0;
            pix_if.mag_up_right   = '0;
            pix_if.mag_down_left  = '0;
            pix_if.mag_down_right = '0;
            pix_if.on_border      = 1'b0;
        end
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Border words, a zero centre, and a weak centre among strong neighbours.
        directed_words.push_back(make_pixel(1234, -567, 20000, 100, 1'b1));
        directed_words.push_back(make_pixel(-32768, 32767, 32767, 32767, 1'b1));
        directed_words.push_back(make_pixel(300, 200, 0, 0, 1'b0));
        directed_words.push_back(make_pixel(300, 200, 1, 32767, 1'b0));
        // One strong-centre word per gradient sector.
        directed_words.push_back(make_pixel(100, 30, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(30, 100, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(100, -30, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(30, -100, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(-100, 30, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(-30, 100, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(-100, -30, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(-30, -100, 32767, 0, 1'b0));
        // Equal gradient magnitudes in every quadrant.
        directed_words.push_back(make_pixel(50, 50, 20000, 1000, 1'b0));
        directed_words.push_back(make_pixel(50, -50, 20000, 1000, 1'b0));
        directed_words.push_back(make_pixel(-50, 50, 20000, 1000, 1'b0));
        directed_words.push_back(make_pixel(-50, -50, 20000, 1000, 1'b0));
        // Gradient extremes, a zero gradient and flat neighbourhoods.
        directed_words.push_back(make_pixel(-32768, -32768, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(32767, -32768, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(-32768, 32767, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(32767, 32767, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(0, 0, 32767, 0, 1'b0));
        directed_words.push_back(make_pixel(-32768, -32768, 16000, 16000, 1'b0));
        directed_words.push_back(make_pixel(32767, 0, 32767, 32767, 1'b0));
        foreach (directed_words[i]) begin
            send_pixel(directed_words[i], draw_gap(1'b0));
        end
        pix_if.valid = 1'b0;
        wait_drained();

        for (int n = 0; n < RandomWords; n++) begin
            if (n % 64 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n == 1200) begin
                pix_if.valid = 1'b0;
                wait_drained();
            end
            p.on_border = ($urandom_range(0, 15) == 0);
            case ($urandom_range(0, 7))
                0: begin
                    p.grad_x = pick_extreme();
                    p.grad_y = pick_extreme();
                end
                1: begin
                    p.grad_x = 16'($urandom);
                    p.grad_y = $urandom_range(0, 1) ? p.grad_x : -p.grad_x;
                end
                2: begin
                    p.grad_x = 16'(int'($urandom_range(0, 8)) - 4);
                    p.grad_y = 16'(int'($urandom_range(0, 8)) - 4);
                end
                default: begin
                    p.grad_x = 16'($urandom);
                    p.grad_y = 16'($urandom);
                end
            endcase
            c = ($urandom_range(0, 31) == 0) ? 0 : int'($urandom_range(1, 32767));
            p.mag_center = 15'(c);
            mode = $urandom_range(0, 4);
            for (int k = 0; k < 8; k++) begin
                case (mode)
                    0, 1: nb[k] = 15'($urandom_range(0, c));
                    2: nb[k] = 15'($urandom_range(0, 32767));
                    3: nb[k] = $urandom_range(0, 1) ? 15'(c) : 15'($urandom_range(0, c));
                    default: begin
                        d = c + int'($urandom_range(0, 4)) - 2;
                        if (d < 0) begin
                            d = 0;
                        end
                        if (d > 32767) begin
                            d = 32767;
                        end
                        nb[k] = 15'(d);
                    end
                endcase
            end
            p.mag_up         = nb[0];
            p.mag_down       = nb[1];
            p.mag_left       = nb[2];
            p.mag_right      = nb[3];
            p.mag_up_left    = nb[4];
            p.mag_up_right   = nb[5];
            p.mag_down_left  = nb[6];
            p.mag_down_right = nb[7];
            send_pixel(p, draw_gap(tx_quiet));
        end
        pix_if.valid = 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_classes.size() == 0) begin
            $display("edge_non_max_suppression verification clean");
        end else begin
            $display("edge_non_max_suppression verification failed");
        end
        $finish;
    end

endmodule
